@@ design/p1305_pkg.sv @@
// Shared types and constants for the Poly1305 authenticator.
`timescale 1ns / 1ps
package p1305_pkg;

    localparam int LIMB_W  = 26;
    localparam int NLIMB   = 5;
    localparam int HLIMB_W = 28;
    localparam int COEF_W  = 29;
    localparam int DLIMB_W = 64;
    localparam int VW      = 132;
    localparam int MAC_STEPS = NLIMB * NLIMB;

    localparam logic [127:0] R_CLAMP = 128'h0ffffffc0ffffffc0ffffffc0fffffff;

    localparam logic [2:0] CFG_R_LOW  = 3'd0;
    localparam logic [2:0] CFG_R_HIGH = 3'd1;
    localparam logic [2:0] CFG_S_LOW  = 3'd2;
    localparam logic [2:0] CFG_S_HIGH = 3'd3;

    typedef struct packed {
        logic       accept;
        logic       load;
        logic       mul_issue;
        logic       mul_acc;
        logic [2:0] mac_i;
        logic [2:0] mac_k;
        logic       carry;
        logic [1:0] carry_idx;
        logic       wrap1;
        logic       wrap2;
        logic       fin1;
        logic       fin2;
        logic       fin3;
        logic       fin4;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

@@ design/p1305_dp.sv @@
// Datapath: key registers, limb accumulator, shared multiplier and final reduction.
`timescale 1ns / 1ps
module p1305_dp
    import p1305_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    output t_stat         o_stat,
    input  logic [127:0]  i_blk,
    input  logic [4:0]    i_count,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_data,
    output logic [127:0]  o_tag,
    output logic          o_tag_valid,
    input  logic          i_tag_ready
);

    localparam logic [DLIMB_W-1:0] LMASK = DLIMB_W'(64'h3FFFFFF);

    logic [63:0]          r_key_r_lo, r_key_r_hi, r_key_s_lo, r_key_s_hi;
    logic [128:0]         r_m, n_m;
    logic [HLIMB_W-1:0]   r_h [NLIMB];
    logic [DLIMB_W-1:0]   r_d [NLIMB];
    logic [DLIMB_W-1:0]   n_d [NLIMB];
    logic [56:0]          r_prod;
    logic [2:0]           r_prod_k;
    logic [VW-1:0]        r_v, n_v;
    logic [127:0]         r_tag;
    logic                 r_tag_valid;

    logic [127:0]         rc;
    logic [COEF_W-1:0]    rl [NLIMB];
    logic [COEF_W-1:0]    r5 [NLIMB];
    logic [COEF_W-1:0]    coef;
    logic [HLIMB_W-1:0]   mul_h;
    logic [VW-1:0]        g;
    logic [37:0]          wrap_c;

    // Clamped r split into radix 2^26 limbs, and the 5*r limbs used for wrap terms.
    always_comb begin
        rc = {r_key_r_hi, r_key_r_lo} & R_CLAMP;
        for (int j = 0; j < NLIMB - 1; j++) begin
            rl[j] = COEF_W'(rc[j*LIMB_W +: LIMB_W]);
        end
        rl[NLIMB-1] = COEF_W'(rc[127:104]);
        for (int j = 0; j < NLIMB; j++) begin
            r5[j] = COEF_W'({rl[j], 2'b00}) + rl[j];
        end
    end

    // Padded message: bytes past the count read as zero, a one byte marks the end.
    always_comb begin
        n_m = r_m;
        if (i_cmd.accept) begin
            for (int b = 0; b < 16; b++) begin
                if (i_count >= 5'd16 || 5'(b) < i_count) begin
                    n_m[b*8 +: 8] = i_blk[b*8 +: 8];
                end else if (5'(b) == i_count) begin
                    n_m[b*8 +: 8] = 8'h01;
                end else begin
                    n_m[b*8 +: 8] = 8'h00;
                end
            end
            n_m[128] = (i_count >= 5'd16);
        end
    end

    always_comb begin
        mul_h = r_h[i_cmd.mac_i];
        if (i_cmd.mac_k >= i_cmd.mac_i) begin
            coef = rl[3'(i_cmd.mac_k - i_cmd.mac_i)];
        end else begin
            coef = r5[3'(i_cmd.mac_k + 3'd5 - i_cmd.mac_i)];
        end
    end

    always_comb begin
        for (int j = 0; j < NLIMB; j++) begin
            n_d[j] = r_d[j];
        end
        wrap_c = 38'(r_d[4] >> LIMB_W);
        if (i_cmd.load) begin
            for (int j = 0; j < NLIMB; j++) begin
                n_d[j] = '0;
            end
        end else if (i_cmd.mul_acc) begin
            for (int j = 0; j < NLIMB; j++) begin
                if (3'(j) == r_prod_k) begin
                    n_d[j] = r_d[j] + DLIMB_W'(r_prod);
                end
            end
        end else if (i_cmd.carry) begin
            for (int j = 0; j < NLIMB - 1; j++) begin
                if (2'(j) == i_cmd.carry_idx) begin
                    n_d[j + 1] = r_d[j + 1] + (r_d[j] >> LIMB_W);
                    n_d[j]     = r_d[j] & LMASK;
                end
            end
        end else if (i_cmd.wrap1) begin
            n_d[4] = r_d[4] & LMASK;
            n_d[0] = r_d[0] + DLIMB_W'({wrap_c, 2'b00}) + DLIMB_W'(wrap_c);
        end else if (i_cmd.wrap2) begin
            n_d[1] = r_d[1] + (r_d[0] >> LIMB_W);
            n_d[0] = r_d[0] & LMASK;
        end else if (i_cmd.fin4 && o_stat.out_free) begin
            for (int j = 0; j < NLIMB; j++) begin
                n_d[j] = '0;
            end
        end
    end

    always_comb begin
        g   = r_v + VW'(5);
        n_v = r_v;
        if (i_cmd.fin1) begin
            n_v = {2'b00, r_d[4][25:0], r_d[3][25:0], r_d[2][25:0], 26'd0, r_d[0][25:0]}
                + (VW'(r_d[1][26:0]) << LIMB_W);
        end else if (i_cmd.fin2) begin
            n_v = VW'(r_v[129:0]) + VW'({r_v[131:130], 2'b00}) + VW'(r_v[131:130]);
        end else if (i_cmd.fin3) begin
            // Subtract p once when the value is at least 2^130 - 5.
            if (g[130]) begin
                n_v = VW'(g[129:0]);
            end
        end
    end

    assign o_stat.out_free = !r_tag_valid || i_tag_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_r_lo  <= '0;
            r_key_r_hi  <= '0;
            r_key_s_lo  <= '0;
            r_key_s_hi  <= '0;
            r_tag_valid <= 1'b0;
            for (int j = 0; j < NLIMB; j++) begin
                r_d[j] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_R_LOW:  r_key_r_lo <= i_cfg_data;
                    CFG_R_HIGH: r_key_r_hi <= i_cfg_data;
                    CFG_S_LOW:  r_key_s_lo <= i_cfg_data;
                    CFG_S_HIGH: r_key_s_hi <= i_cfg_data;
                    default: ;
                endcase
            end
            for (int j = 0; j < NLIMB; j++) begin
                r_d[j] <= n_d[j];
            end
            if (i_cmd.fin4 && o_stat.out_free) begin
                r_tag_valid <= 1'b1;
            end else if (i_tag_ready) begin
                r_tag_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m <= n_m;
        r_v <= n_v;
        if (i_cmd.load) begin
            r_h[0] <= r_d[0][HLIMB_W-1:0] + HLIMB_W'(r_m[25:0]);
            r_h[1] <= r_d[1][HLIMB_W-1:0] + HLIMB_W'(r_m[51:26]);
            r_h[2] <= r_d[2][HLIMB_W-1:0] + HLIMB_W'(r_m[77:52]);
            r_h[3] <= r_d[3][HLIMB_W-1:0] + HLIMB_W'(r_m[103:78]);
            r_h[4] <= r_d[4][HLIMB_W-1:0] + HLIMB_W'(r_m[128:104]);
        end
        if (i_cmd.mul_issue) begin
            r_prod   <= 57'(mul_h) * 57'(coef);
            r_prod_k <= i_cmd.mac_k;
        end
        if (i_cmd.fin4 && o_stat.out_free) begin
            r_tag <= r_v[127:0] + {r_key_s_hi, r_key_s_lo};
        end
    end

    assign o_tag       = r_tag;
    assign o_tag_valid = r_tag_valid;

endmodule

@@ design/p1305_ctrl.sv @@
// Controller: sequences load, multiply-accumulate, carry and finish steps.
`timescale 1ns / 1ps
module p1305_ctrl
    import p1305_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_last,
    input  logic  i_nonempty,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_LOAD  = 10'b00_0000_0010,
        S_MUL   = 10'b00_0000_0100,
        S_CARRY = 10'b00_0000_1000,
        S_WRAP1 = 10'b00_0001_0000,
        S_WRAP2 = 10'b00_0010_0000,
        S_FIN1  = 10'b00_0100_0000,
        S_FIN2  = 10'b00_1000_0000,
        S_FIN3  = 10'b01_0000_0000,
        S_FIN4  = 10'b10_0000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic [2:0] r_i, n_i, r_k, n_k;
    logic       r_last, n_last;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_i     = r_i;
        n_k     = r_k;
        n_last  = r_last;
        o_cmd   = '0;
        o_cmd.mac_i     = r_i;
        o_cmd.mac_k     = r_k;
        o_cmd.carry_idx = r_cnt[1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_last = i_last;
                    if (i_nonempty) begin
                        n_state = S_LOAD;
                    end else if (i_last) begin
                        n_state = S_FIN1;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_cnt   = '0;
                n_i     = '0;
                n_k     = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_issue = (r_cnt < 5'(MAC_STEPS));
                o_cmd.mul_acc   = (r_cnt != 5'd0);
                if (r_k == 3'(NLIMB - 1)) begin
                    n_k = '0;
                    n_i = r_i + 3'd1;
                end else begin
                    n_k = r_k + 3'd1;
                end
                if (r_cnt == 5'(MAC_STEPS)) begin
                    n_cnt   = '0;
                    n_state = S_CARRY;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_CARRY: begin
                o_cmd.carry = 1'b1;
                if (r_cnt == 5'd3) begin
                    n_cnt   = '0;
                    n_state = S_WRAP1;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_WRAP1: begin
                o_cmd.wrap1 = 1'b1;
                n_state = S_WRAP2;
            end
            S_WRAP2: begin
                o_cmd.wrap2 = 1'b1;
                n_state = r_last ? S_FIN1 : S_IDLE;
            end
            S_FIN1: begin
                o_cmd.fin1 = 1'b1;
                n_state = S_FIN2;
            end
            S_FIN2: begin
                o_cmd.fin2 = 1'b1;
                n_state = S_FIN3;
            end
            S_FIN3: begin
                o_cmd.fin3 = 1'b1;
                n_state = S_FIN4;
            end
            S_FIN4: begin
                // Holds here while the previous tag still waits at the output.
                o_cmd.fin4 = 1'b1;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_i     <= '0;
            r_k     <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_i     <= n_i;
            r_k     <= n_k;
            r_last  <= n_last;
        end
    end

    a_mul_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && r_cnt == 5'(MAC_STEPS)) |=> (r_state == S_CARRY))
        else $error("multiply phase did not hand over to carry");

    a_load_after_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_valid && i_nonempty) |=> (r_state == S_LOAD))
        else $error("request with data did not start a load");

    a_empty_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_valid && !i_nonempty && !i_last) |=> (r_state == S_IDLE))
        else $error("empty non-final request left idle");

    a_mac_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mul_issue |-> (r_i < 3'(NLIMB) && r_k < 3'(NLIMB)))
        else $error("multiply limb index out of range");

endmodule

@@ design/poly1305_mac.sv @@
// Top level of the Poly1305 one-time authenticator.
`timescale 1ns / 1ps
// Poly1305 MAC. Write the 32-byte key as four 64-bit registers (r low/high, s
// low/high) on the config channel while the block is idle; r is clamped
// internally. Each request on the slave stream carries one 16-byte block and its
// byte count; tlast marks the final block, after which the tag appears on the
// master stream and the accumulator clears. A block with data passes through
// accept, load, 25 limb products through one shared 28x29 multiplier plus a drain
// of the product register, four carry steps and two wrap steps; a final block
// then adds full reduction and pad addition, and an empty final block goes from
// accept straight to them. An empty non-final block is only accepted and leaves
// the block idle and ready. The finished tag sits in an output register, so the
// next message can start while the tag waits to be taken.
module poly1305_mac
    import p1305_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // block_low [63:0], block_high [127:64], byte_count [132:128], zero pad
    input  logic [135:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tag_low [63:0], tag_high [127:64]
    output logic [127:0] m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    p1305_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .i_last     (s_axis_tlast),
        .i_nonempty (s_axis_tdata[132:128] != 5'd0),
        .o_ready    (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    p1305_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_blk       (s_axis_tdata[127:0]),
        .i_count     (s_axis_tdata[132:128]),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_tag       (m_axis_tdata),
        .o_tag_valid (m_axis_tvalid),
        .i_tag_ready (m_axis_tready)
    );

endmodule

@@ sim/poly1305_mac_tb.sv @@
// Self-checking testbench for the Poly1305 authenticator top level.
`timescale 1ns / 1ps
module poly1305_mac_tb;
    import p1305_pkg::*;

    localparam logic [130:0] PRIME = (131'd1 << 130) - 131'd5;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int IDLE_CYCLES = 60;

    typedef struct {
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  cnt;
        logic        last;
    } t_block_req;

    typedef struct {
        logic [63:0] lo;
        logic [63:0] hi;
    } t_tag;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index;
    logic [63:0]  i_cfg_data;

    t_block_req   pending_blocks[$];
    t_tag         expected_tags[$];
    logic [129:0] mac_acc;
    logic [63:0]  key_reg[4];
    int           errors;
    int           tags_seen;
    int           blocks_sent;
    int           key_settings;
    int           cycles;
    int           burst_left;
    int           gap_left;
    int           stall_mode;

    poly1305_mac i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // (a * r) mod 2^130-5, folded with 2^130 = 5 and then fully reduced.
    function automatic logic [129:0] mul_mod_p(logic [130:0] a, logic [127:0] r);
        logic [259:0] x;
        x = a * r;
        repeat (3) x = x[129:0] + x[259:130] * 5;
        while (x >= PRIME) x = x - PRIME;
        return x[129:0];
    endfunction

    // Folds one block into the accumulator and returns 1 with the tag on a last block.
    function automatic bit absorb_block(t_block_req b, output t_tag t);
        logic [127:0] r;
        logic [130:0] m;
        logic [129:0] full;
        int           n;
        r = {key_reg[CFG_R_HIGH[1:0]], key_reg[CFG_R_LOW[1:0]]} & R_CLAMP;
        n = (b.cnt >= 16) ? 16 : b.cnt;
        m = {3'b0, b.hi, b.lo};
        if (n == 16) begin
            m[128] = 1'b1;
        end else if (n > 0) begin
            m = m & ((131'd1 << (8 * n)) - 1);
            m[8 * n] = 1'b1;
        end
        if (n > 0) mac_acc = mul_mod_p(mac_acc + m, r);
        if (!b.last) return 0;
        full = mac_acc + {key_reg[CFG_S_HIGH[1:0]], key_reg[CFG_S_LOW[1:0]]};
        t.lo = full[63:0];
        t.hi = full[127:64];
        mac_acc = '0;
        return 1;
    endfunction

    // Model update and output check, both sampled at the same edge as the DUT.
    always @(posedge i_clk) begin
        t_tag t;
        t_tag want;
        t_block_req b;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready && i_cfg_index <= CFG_S_HIGH)
                key_reg[i_cfg_index[1:0]] <= i_cfg_data;
            if (s_axis_tvalid && s_axis_tready) begin
                b.lo = s_axis_tdata[63:0];
                b.hi = s_axis_tdata[127:64];
                b.cnt = s_axis_tdata[132:128];
                b.last = s_axis_tlast;
                blocks_sent++;
                if (absorb_block(b, t)) expected_tags.push_back(t);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                tags_seen++;
                if (expected_tags.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected tag %h", $time, m_axis_tdata);
                end else begin
                    want = expected_tags.pop_front();
                    if (m_axis_tdata[63:0] !== want.lo) begin
                        errors++;
                        $display("%0t: tag_low expected %h actual %h", $time, want.lo,
                                 m_axis_tdata[63:0]);
                    end
                    if (m_axis_tdata[127:64] !== want.hi) begin
                        errors++;
                        $display("%0t: tag_high expected %h actual %h", $time, want.hi,
                                 m_axis_tdata[127:64]);
                    end
                end
            end
        end
    end

    // Sender: bursts of requests separated by random gaps.
    always @(posedge i_clk) begin
        t_block_req b;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left <= 1;
            gap_left <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left > 0) begin
                s_axis_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_blocks.size() > 0) begin
                b = pending_blocks.pop_front();
                s_axis_tdata <= {3'b0, b.cnt, b.hi, b.lo};
                s_axis_tlast <= b.last;
                s_axis_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: alternates between always ready, light stalls and heavy stalls.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d tags outstanding", $time, expected_tags.size());
            $display("poly1305_mac_tb NOT OK");
            $finish;
        end
    end

    task automatic add_block(logic [63:0] lo, logic [63:0] hi, int cnt, bit last);
        t_block_req b;
        b.lo = lo;
        b.hi = hi;
        b.cnt = 5'(cnt);
        b.last = last;
        pending_blocks.push_back(b);
    endtask

    task automatic write_key(logic [2:0] idx, logic [63:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(posedge i_clk);
        while (pending_blocks.size() > 0 || s_axis_tvalid || expected_tags.size() > 0)
            @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_key(int kind);
        logic [63:0] v;
        for (int i = 0; i < 4; i++) begin
            v = (kind == 0) ? 64'd0 : (kind == 1) ? '1 : rand64();
            write_key(i[2:0], v);
        end
        // Indexes above the last key word must not disturb anything.
        write_key(3'($urandom_range(4, 7)), rand64());
        key_settings++;
    endtask

    // Mostly well-formed messages; now and then odd counts and short middle blocks.
    task automatic add_message();
        int nblk;
        int cnt;
        nblk = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 4);
        for (int i = 0; i < nblk; i++) begin
            case ($urandom_range(0, 19))
                0: cnt = $urandom_range(0, 15);
                1: cnt = $urandom_range(17, 31);
                default: cnt = 16;
            endcase
            add_block(rand64(), rand64(), cnt, 1'b0);
        end
        cnt = ($urandom_range(0, 3) == 0) ? 16 : $urandom_range(0, 31);
        add_block(rand64(), rand64(), cnt, 1'b1);
    endtask

    initial begin
        int ph;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        mac_acc = '0;
        foreach (key_reg[i]) key_reg[i] = '0;
        errors = 0;
        tags_seen = 0;
        blocks_sent = 0;
        key_settings = 0;
        cycles = 0;
        stall_mode = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (ph = 0; ph < 9; ph++) begin
            load_key(ph < 2 ? ph : 2);
            if (ph < 2) begin
                // Field extremes, every byte count edge, empty and short middle blocks.
                add_block('1, '1, 16, 1'b1);
                add_block('0, '0, 0, 1'b1);
                add_block('1, '1, 16, 1'b0);
                add_block('1, '1, 16, 1'b0);
                add_block('1, '1, 15, 1'b1);
                add_block(rand64(), rand64(), 1, 1'b1);
                add_block(rand64(), rand64(), 7, 1'b1);
                add_block(rand64(), rand64(), 8, 1'b1);
                add_block(rand64(), rand64(), 9, 1'b1);
                add_block(rand64(), rand64(), 31, 1'b0);
                add_block(rand64(), rand64(), 3, 1'b0);
                add_block(rand64(), rand64(), 0, 1'b0);
                add_block(rand64(), rand64(), 17, 1'b1);
            end else begin
                while (pending_blocks.size() < 230) add_message();
            end
            wait_idle();
        end

        $display("Ran %0d blocks under %0d key settings, %0d tags checked.",
                 blocks_sent, key_settings, tags_seen);
        $display("Covered zero and all-ones keys, byte counts 0 to 31, short middle blocks.");
        if (errors == 0 && expected_tags.size() == 0) begin
            $display("poly1305_mac_tb OK");
        end else begin
            $display("poly1305_mac_tb NOT OK");
        end
        $finish;
    end

endmodule
